[design/mpp_pkg.sv]
// Shared types and constants of the masked pattern patcher.
package mpp_pkg;

   localparam int WINDOW_DEPTH = 32;
   localparam int FILL_W      = $clog2(WINDOW_DEPTH + 1);
   localparam int IDX_W       = $clog2(WINDOW_DEPTH);
   localparam logic [4:0]  FIELD_MASK = 5'h1F;
   localparam logic [15:0] HITS_MAX   = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_DATA  = 2'd1,
      OP_FLUSH = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [4:0]  entry_index;
      logic [7:0]  match_byte;
      logic        match_care;
      logic [7:0]  patch_byte;
      logic        patch_enable;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_last;
      logic        found;
      logic [15:0] match_count;
      logic [31:0] last_offset;
      logic [4:0]  captured_field;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_EMIT,
      ST_FLUSH
   } ctl_state_type;

   typedef struct packed {
      logic load_entry;
      logic shift_in;
      logic match_test;
      logic emit_leaving;
      logic flush_start;
      logic flush_emit;
      logic flush_clear;
   } dp_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic emitting;
      logic window_empty;
      logic flush_last;
   } dp_status_type;

endpackage

[design/mpp_ctrl.sv]
// Sequencing state machine of the masked pattern patcher.
module mpp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  mpp_pkg::op_type       req_op,
   input  mpp_pkg::dp_status_type status,
   output logic                  req_ready,
   output mpp_pkg::dp_cmd_type   cmd
);
   import mpp_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_op)
                  OP_LOAD: begin
                     cmd.load_entry = 1'b1;
                  end
                  OP_DATA: begin
                     cmd.shift_in = 1'b1;
                     state_in     = ST_MATCH;
                  end
                  OP_FLUSH: begin
                     // An empty window drains nothing; only the stream counters clear.
                     if (status.window_empty) begin
                        cmd.flush_clear = 1'b1;
                     end else begin
                        cmd.flush_start = 1'b1;
                        state_in        = ST_FLUSH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MATCH: begin
            cmd.match_test = 1'b1;
            state_in       = status.emitting ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (status.slot_free) begin
               cmd.emit_leaving = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (status.slot_free) begin
               cmd.flush_emit = 1'b1;
               if (status.flush_last) begin
                  cmd.flush_clear = 1'b1;
                  state_in        = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[design/mpp_datapath.sv]
// Window, pattern table, match compare, statistics and output register.
module mpp_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  mpp_pkg::req_type       req_payload,
   input  mpp_pkg::dp_cmd_type    cmd,
   output mpp_pkg::dp_status_type status,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output mpp_pkg::rsp_type       rsp_payload
);
   import mpp_pkg::*;

   localparam logic [FILL_W-1:0] FULL_LEVEL = FILL_W'(WINDOW_DEPTH);

   // Window is right aligned: new bytes enter at the top, the oldest sits at the bottom
   // once the window is full.
   logic [7:0]        window_ff [WINDOW_DEPTH];
   logic [7:0]        window_in [WINDOW_DEPTH];
   logic [7:0]        pat_ff    [WINDOW_DEPTH];
   logic [7:0]        rep_ff    [WINDOW_DEPTH];
   logic              care_ff   [WINDOW_DEPTH];
   logic              enable_ff [WINDOW_DEPTH];

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] skip_ff, skip_in;
   logic [FILL_W-1:0] rem_ff, rem_in;
   logic [31:0]       pos_ff, pos_in;
   logic [15:0]       hits_ff, hits_in;
   logic [31:0]       hit_off_ff, hit_off_in;
   logic [4:0]        hit_field_ff, hit_field_in;
   logic [7:0]        leave_ff, leave_in;
   logic              emitting_ff, emitting_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              window_hit;
   logic              slot_free;
   logic [IDX_W-1:0]  rd_idx;
   logic [IDX_W-1:0]  wr_idx;
   logic              wr_ok;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rd_idx    = IDX_W'(FULL_LEVEL - rem_ff);
   assign wr_idx    = IDX_W'(req_payload.entry_index);
   assign wr_ok     = 32'(req_payload.entry_index) < 32'(WINDOW_DEPTH);

   always_comb begin
      window_hit = 1'b1;
      for (int j = 0; j < WINDOW_DEPTH; j++) begin
         window_hit = window_hit & (!care_ff[j] || (window_ff[j] == pat_ff[j]));
      end
   end

   always_comb begin
      window_in    = window_ff;
      fill_in      = fill_ff;
      skip_in      = skip_ff;
      rem_in       = rem_ff;
      pos_in       = pos_ff;
      hits_in      = hits_ff;
      hit_off_in   = hit_off_ff;
      hit_field_in = hit_field_ff;
      leave_in     = leave_ff;
      emitting_in  = emitting_ff;

      if (cmd.shift_in) begin
         emitting_in = (fill_ff == FULL_LEVEL);
         leave_in    = window_ff[0];
         for (int j = 0; j < WINDOW_DEPTH - 1; j++) begin
            window_in[j] = window_ff[j + 1];
         end
         window_in[WINDOW_DEPTH - 1] = req_payload.data_byte;
         if (fill_ff != FULL_LEVEL) begin
            fill_in = fill_ff + FILL_W'(1);
         end
         pos_in = pos_ff + 32'd1;
      end

      if (cmd.match_test && (fill_ff == FULL_LEVEL)) begin
         if (skip_ff != '0) begin
            skip_in = skip_ff - FILL_W'(1);
         end else if (window_hit) begin
            hit_field_in = window_ff[0][4:0] & FIELD_MASK;
            hit_off_in   = pos_ff - 32'(WINDOW_DEPTH);
            for (int j = 0; j < WINDOW_DEPTH; j++) begin
               if (enable_ff[j]) begin
                  window_in[j] = rep_ff[j];
               end
            end
            if (hits_ff != HITS_MAX) begin
               hits_in = hits_ff + 16'd1;
            end
            skip_in = FILL_W'(WINDOW_DEPTH - 1);
         end
      end

      if (cmd.flush_start) begin
         rem_in = fill_ff;
      end
      if (cmd.flush_emit) begin
         rem_in = rem_ff - FILL_W'(1);
      end
      if (cmd.flush_clear) begin
         fill_in = '0;
         skip_in = '0;
         pos_in  = '0;
      end
   end

   always_comb begin
      rsp_in               = rsp_ff;
      rsp_valid_in         = rsp_valid_ff && !rsp_ready;
      rsp_in.found         = (hits_ff != '0);
      rsp_in.match_count   = hits_ff;
      rsp_in.last_offset   = hit_off_ff;
      rsp_in.captured_field = hit_field_ff;
      if (cmd.emit_leaving) begin
         rsp_valid_in    = 1'b1;
         rsp_in.out_byte = leave_ff;
         rsp_in.is_last  = 1'b0;
      end else if (cmd.flush_emit) begin
         rsp_valid_in    = 1'b1;
         rsp_in.out_byte = window_ff[rd_idx];
         rsp_in.is_last  = (rem_ff == FILL_W'(1));
      end else begin
         rsp_in = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         skip_ff      <= '0;
         rem_ff       <= '0;
         pos_ff       <= '0;
         hits_ff      <= '0;
         hit_off_ff   <= '0;
         hit_field_ff <= '0;
         emitting_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < WINDOW_DEPTH; j++) begin
            care_ff[j]   <= 1'b0;
            enable_ff[j] <= 1'b0;
         end
      end else begin
         fill_ff      <= fill_in;
         skip_ff      <= skip_in;
         rem_ff       <= rem_in;
         pos_ff       <= pos_in;
         hits_ff      <= hits_in;
         hit_off_ff   <= hit_off_in;
         hit_field_ff <= hit_field_in;
         emitting_ff  <= emitting_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.load_entry && wr_ok) begin
            care_ff[wr_idx]   <= req_payload.match_care;
            enable_ff[wr_idx] <= req_payload.patch_enable;
         end
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      leave_ff  <= leave_in;
      rsp_ff    <= rsp_in;
      if (cmd.load_entry && wr_ok) begin
         pat_ff[wr_idx] <= req_payload.match_byte;
         rep_ff[wr_idx] <= req_payload.patch_byte;
      end
   end

   assign status.slot_free    = slot_free;
   assign status.emitting     = emitting_ff;
   assign status.window_empty = (fill_ff == '0);
   assign status.flush_last   = (rem_ff == FILL_W'(1));

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[design/masked_pattern_patcher_core.sv]
// Top level of the masked pattern patcher: controller plus datapath.
//
// Wildcard byte-pattern search and patch engine. Request beats arrive on the
// req_ channel (valid/ready); each carries an op. A load op writes one pattern
// entry (match byte, care bit, patch byte, patch enable).
// A data op shifts one byte into a 32-byte window; once the window is full the
// cared positions are compared in parallel against the pattern, and on a match
// the enabled positions are patched and the match statistics updated. Matches
// never overlap: the next 31 candidate starts after a match are skipped.
// A data beat on a full window produces one response beat carrying the byte
// that left the window; a data beat passes the shift and compare steps, and
// the output register step too when it produces a response.
// A flush op drains the buffered bytes one per cycle while the output register
// is free, the final one marked is_last, then restarts offsets at zero.
// Response beats leave through a single output register on the rsp_ channel.
// When the receiver holds rsp_ready low the engine waits with its next result
// and stops taking request beats until that register can be reloaded.
// Synchronous reset clears the window fill, counters, match statistics and the
// care and enable bits of every pattern entry; no response is pending after it.
module masked_pattern_patcher_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mpp_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mpp_pkg::rsp_type rsp_payload
);
   import mpp_pkg::*;

   // Command and status bundles between the sequencer and the datapath.
   dp_cmd_type    cmd;
   dp_status_type status;

   // The sequencer takes one request beat at a time and steps the datapath.
   mpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_payload.op),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // The datapath holds the window, the pattern table and the response register.
   mpp_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

[design/mpp_checker.sv]
// Port-level assertions of the masked pattern patcher, bound to the top level.
module mpp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input mpp_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mpp_pkg::rsp_type rsp_payload
);
   import mpp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("response payload changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending right after reset");

   a_data_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_payload.op == OP_DATA) |=> !req_ready)
      else $error("request taken while a data beat is still in work");

   a_found_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.found == (rsp_payload.match_count != '0)))
      else $error("found flag disagrees with match count");

endmodule

bind masked_pattern_patcher_core mpp_checker u_mpp_checker (.*);

[tb/sv/tb_top.sv]
// Self-checking testbench for the masked pattern patcher core.
`timescale 1ns / 100ps

module tb_top;
   import mpp_pkg::*;

   // A request beat waiting to be sent. When hold_for_drain is set, the
   // sender keeps valid low until every expected output beat has arrived.
   typedef struct {
      req_type beat;
      bit      hold_for_drain;
   } queued_req_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   masked_pattern_patcher_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   queued_req_type pending_reqs[$];
   rsp_type        outgoing_bytes[$];
   int             failures      = 0;
   int             counted_items = 0;
   int             send_gap      = 0;
   int             recv_stall    = 0;
   // Set once the sender is near the end of its queue; from then on neither
   // side starts a new random idle burst. Written with a nonblocking
   // assignment so that the receiver always sees the value from before the edge.
   bit             quiet_tail    = 1'b0;

   // ---------------------------------------------------------------------
   // Shadow copy of the engine: window, pattern table and match statistics.
   // ---------------------------------------------------------------------
   logic [7:0]  win_bytes  [WINDOW_DEPTH] = '{default: '0};
   logic [7:0]  pat_match  [WINDOW_DEPTH] = '{default: '0};
   logic        pat_care   [WINDOW_DEPTH] = '{default: '0};
   logic [7:0]  pat_patch  [WINDOW_DEPTH] = '{default: '0};
   logic        pat_enable [WINDOW_DEPTH] = '{default: '0};
   int          win_fill   = 0;
   int          skip_count = 0;
   logic [31:0] stream_pos = '0;
   logic [15:0] hit_count  = '0;
   logic [31:0] hit_offset = '0;
   logic [4:0]  hit_field  = '0;

   // Builds one output beat from a byte leaving the window and the match
   // statistics as they stand after the current step.
   function automatic rsp_type leaving_beat(input logic [7:0] b, input logic last);
      rsp_type r;
      r.out_byte       = b;
      r.is_last        = last;
      r.found          = (hit_count != '0);
      r.match_count    = hit_count;
      r.last_offset    = hit_offset;
      r.captured_field = hit_field;
      return r;
   endfunction

   // Advances the shadow engine by one accepted request beat and queues the
   // output beats it causes.
   task automatic apply_req_beat(input req_type r);
      logic [7:0] leaving;
      bit         emitting;
      bit         hit;
      int         j;
      int         cnt;
      leaving  = '0;
      emitting = 1'b0;
      case (r.op)
         OP_LOAD: begin
            // The 5-bit index always addresses one of the 32 entries.
            pat_match[r.entry_index]  = r.match_byte;
            pat_care[r.entry_index]   = r.match_care;
            pat_patch[r.entry_index]  = r.patch_byte;
            pat_enable[r.entry_index] = r.patch_enable;
         end
         OP_DATA: begin
            // A full window pushes its oldest byte out before the new one enters.
            if (win_fill >= WINDOW_DEPTH) begin
               leaving  = win_bytes[0];
               emitting = 1'b1;
               for (j = 1; j < WINDOW_DEPTH; j++)
                  win_bytes[j-1] = win_bytes[j];
               win_fill = WINDOW_DEPTH - 1;
            end
            win_bytes[win_fill] = r.data_byte;
            win_fill++;
            stream_pos++;
            if (win_fill == WINDOW_DEPTH) begin
               if (skip_count > 0) begin
                  // Still inside the previous match; no overlap allowed.
                  skip_count--;
               end else begin
                  hit = 1'b1;
                  for (j = 0; j < WINDOW_DEPTH; j++)
                     if (pat_care[j] && win_bytes[j] != pat_match[j])
                        hit = 1'b0;
                  if (hit) begin
                     // The captured field is taken before the window is patched.
                     hit_field  = win_bytes[0][4:0];
                     hit_offset = stream_pos - WINDOW_DEPTH;
                     for (j = 0; j < WINDOW_DEPTH; j++)
                        if (pat_enable[j])
                           win_bytes[j] = pat_patch[j];
                     if (hit_count != HITS_MAX)
                        hit_count++;
                     skip_count = WINDOW_DEPTH - 1;
                  end
               end
            end
            if (emitting)
               outgoing_bytes.push_back(leaving_beat(leaving, 1'b0));
         end
         OP_FLUSH: begin
            // Drain the window oldest first; statistics survive the flush.
            cnt = win_fill;
            for (j = 0; j < cnt; j++)
               outgoing_bytes.push_back(leaving_beat(win_bytes[j], j + 1 == cnt));
            for (j = 0; j < WINDOW_DEPTH; j++)
               win_bytes[j] = '0;
            win_fill   = 0;
            skip_count = 0;
            stream_pos = '0;
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Sender: presents queued request beats, with random idle bursts.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      queued_req_type next;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            apply_req_beat(req_payload);
         quiet_tail <= (pending_reqs.size() < 40);
         // Valid may only change once the current beat has been taken.
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_reqs[0].hold_for_drain && outgoing_bytes.size() != 0) begin
               req_valid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(1, 17) - 1;
               req_valid <= 1'b0;
            end else begin
               next = pending_reqs.pop_front();
               req_payload <= next.beat;
               req_valid   <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: takes output beats, stalls in random bursts, and compares
   // each beat with the oldest expected one.
   // ---------------------------------------------------------------------
   task automatic check_out_beat(input rsp_type got);
      rsp_type want;
      if (outgoing_bytes.size() == 0) begin
         $error("unexpected output beat: out_byte %0h", got.out_byte);
         failures++;
      end else begin
         want = outgoing_bytes.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
            failures++;
         end
         if (got.is_last !== want.is_last) begin
            $error("is_last: expected %0d, actual %0d", want.is_last, got.is_last);
            failures++;
         end
         if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            failures++;
         end
         if (got.match_count !== want.match_count) begin
            $error("match_count: expected %0d, actual %0d",
                   want.match_count, got.match_count);
            failures++;
         end
         if (got.last_offset !== want.last_offset) begin
            $error("last_offset: expected %0d, actual %0d",
                   want.last_offset, got.last_offset);
            failures++;
         end
         if (got.captured_field !== want.captured_field) begin
            $error("captured_field: expected %0h, actual %0h",
                   want.captured_field, got.captured_field);
            failures++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_out_beat(rsp_payload);
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
            recv_stall = $urandom_range(1, 17) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus. The generator keeps its own record of the loaded pattern so
   // that it can plant matching runs in the byte streams.
   // ---------------------------------------------------------------------
   logic [7:0] gen_match [WINDOW_DEPTH] = '{default: '0};
   logic       gen_care  [WINDOW_DEPTH] = '{default: '0};

   function automatic req_type random_beat(input op_type op);
      logic [63:0] bits;
      req_type     b;
      bits = {$urandom, $urandom};
      b    = bits[$bits(req_type)-1:0];
      b.op = op;
      return b;
   endfunction

   task automatic queue_beat(input req_type b, input bit hold = 1'b0);
      queued_req_type q;
      q.beat           = b;
      q.hold_for_drain = hold;
      pending_reqs.push_back(q);
      if (b.op != OP_NONE)
         counted_items++;
   endtask

   task automatic queue_load(input int idx, input logic [7:0] mb, input logic care,
                             input logic [7:0] pb, input logic en);
      req_type b;
      b = random_beat(OP_LOAD);
      b.entry_index  = idx[4:0];
      b.match_byte   = mb;
      b.match_care   = care;
      b.patch_byte   = pb;
      b.patch_enable = en;
      gen_match[idx] = mb;
      gen_care[idx]  = care;
      queue_beat(b);
   endtask

   task automatic queue_data(input logic [7:0] d);
      req_type b;
      b = random_beat(OP_DATA);
      b.data_byte = d;
      queue_beat(b);
   endtask

   // Loads one entry with random content; care_pct sets how often it is cared.
   task automatic queue_random_entry(input int idx, input int care_pct);
      queue_load(idx, 8'($urandom), $urandom_range(0, 99) < care_pct,
                 8'($urandom), 1'($urandom));
   endtask

   initial begin
      logic [7:0] stream_bytes [0:127];
      int         care_pct;
      int         len;
      int         start;
      int         buffers;
      int         j;
      int         k;
      bit         hold;

      // Directed opening: empty flush, the unused op, extreme entries and
      // a short buffer that cannot match.
      queue_beat(random_beat(OP_FLUSH));
      queue_beat(random_beat(OP_NONE));
      queue_load(0, 8'hFF, 1'b1, 8'h00, 1'b1);
      queue_load(WINDOW_DEPTH - 1, 8'h00, 1'b1, 8'hFF, 1'b1);
      queue_load(15, 8'hA5, 1'b0, 8'h5A, 1'b0);
      queue_load(16, 8'h00, 1'b0, 8'hFF, 1'b0);
      queue_data(8'h00);
      queue_data(8'hFF);
      queue_data(8'h80);
      queue_beat(random_beat(OP_NONE));
      queue_data(8'h7F);
      queue_beat(random_beat(OP_FLUSH));
      queue_beat(random_beat(OP_FLUSH));
      queue_data(8'h01);
      queue_beat(random_beat(OP_FLUSH), 1'b1);

      // Random part: a full pattern load, then buffers with planted matches,
      // occasional pattern edits, noise and loads in mid stream.
      care_pct = 25;
      for (j = 0; j < WINDOW_DEPTH; j++)
         queue_random_entry(j, care_pct);
      buffers = 0;
      while (counted_items < 380) begin
         case ($urandom_range(0, 7))
            0: begin
               // New pattern density; zero gives an all-wildcard pattern that
               // matches at every allowed start.
               case ($urandom_range(0, 3))
                  0: care_pct = 0;
                  1: care_pct = 6;
                  2: care_pct = 25;
                  default: care_pct = 100;
               endcase
               for (j = 0; j < WINDOW_DEPTH; j++)
                  queue_random_entry(j, care_pct);
            end
            1: begin
               repeat ($urandom_range(1, 6))
                  queue_random_entry($urandom_range(0, WINDOW_DEPTH - 1), care_pct);
            end
            default: ;
         endcase

         // Mostly buffers long enough to match, some too short to.
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, WINDOW_DEPTH - 1)
                                           : $urandom_range(WINDOW_DEPTH, 90);
         for (k = 0; k < len; k++)
            stream_bytes[k] = 8'($urandom);
         if (len >= WINDOW_DEPTH) begin
            repeat ($urandom_range(0, 2)) begin
               start = $urandom_range(0, len - WINDOW_DEPTH);
               for (j = 0; j < WINDOW_DEPTH; j++)
                  if (gen_care[j])
                     stream_bytes[start + j] = gen_match[j];
            end
         end
         for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 29) == 0) begin
               if ($urandom_range(0, 1) == 0)
                  queue_beat(random_beat(OP_NONE));
               else
                  queue_random_entry($urandom_range(0, WINDOW_DEPTH - 1), care_pct);
            end
            queue_data(stream_bytes[k]);
         end

         // Now and then the flush waits for every output beat to drain first.
         hold = (buffers == 0) || ($urandom_range(0, 7) == 0);
         if (hold || $urandom_range(0, 9) != 0)
            queue_beat(random_beat(OP_FLUSH), hold);
         buffers++;
      end
      queue_beat(random_beat(OP_FLUSH));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last beat to be taken and every output beat to arrive,
      // then give a full flush time for anything stray to show up.
      while (pending_reqs.size() != 0 || req_valid)
         @(posedge clock);
      while (outgoing_bytes.size() != 0)
         @(posedge clock);
      repeat (2 * WINDOW_DEPTH + 8) @(posedge clock);

      if (failures == 0 && outgoing_bytes.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Generous time limit, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
